### design/fpsig_pkg.sv
// Package for the fixed-point int8 sigmoid: constants and register indexes.
package fpsig_pkg;

  // Q16 constants
  localparam logic [16:0] Q16_ONE     = 17'd65536;
  localparam logic [16:0] INV_LN2_Q16 = 17'd94548;
  localparam logic [15:0] POLY_C1     = 16'd45426;
  localparam logic [15:0] POLY_C2     = 16'd15743;
  localparam logic [15:0] POLY_C3     = 16'd3638;

  // exp input integer part at which the result is zero
  localparam logic [15:0] K_ZERO = 16'd31;

  // quotient bits of the sigmoid divider (quotient never exceeds 65536)
  localparam int DIV_STEPS = 17;

  // configuration register indexes
  localparam logic [7:0] REG_INPUT_SCALE = 8'd0;
  localparam logic [7:0] REG_INV_OUT_SCALE = 8'd1;
  localparam logic [7:0] REG_ACT_MIN = 8'd2;
  localparam logic [7:0] REG_ACT_MAX = 8'd3;

  // register reset values
  localparam logic [23:0] INPUT_SCALE_RESET = 24'd65536;
  localparam logic [30:0] INV_OUT_SCALE_RESET = 31'd16777216;
  localparam logic signed [7:0] ACT_MIN_RESET = -8'sd128;
  localparam logic signed [7:0] ACT_MAX_RESET = 8'sd127;

endpackage

### design/fixed_point_sigmoid_s8.sv
// Top level of the fixed-point int8 sigmoid: a fully pipelined datapath.
//
// Usage:
//   Input channel (sample_valid/sample_ready) carries one signed 8-bit sample
//   and a last flag per transaction. Output channel (result_valid/result_ready)
//   carries the clamped 8-bit sigmoid code and the copied last flag.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   the scale and clamp registers; it is always ready. Write it only while
//   the pipeline is empty. Indexes beyond the register list are ignored.
// Throughput: one sample per cycle while the output is not stalled. A sample
//   passes from accept to the result being presented through 6 stages of exp
//   evaluation, a 17-stage one-bit-per-stage restoring divider, the output
//   scale multiply and the rounding/clamp output register.
// Reset: synchronous, clears all stage valid bits and loads the register
//   defaults. No clearing pass is needed.
// Stall: when the output register holds a result that is not taken, the
//   whole pipeline holds and sample_ready drops; nothing is lost or repeated.
module fixed_point_sigmoid_s8 (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  logic signed [7:0] sample,
  input  logic              last_in,
  output logic              result_valid,
  input  logic              result_ready,
  output logic signed [7:0] result,
  output logic              last_out,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int NS = fpsig_pkg::DIV_STEPS;

  // configuration registers
  logic [23:0]        input_scale_q16;
  logic [30:0]        inverse_output_scale_q16;
  logic signed [7:0]  act_min;
  logic signed [7:0]  act_max;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_scale_q16          <= fpsig_pkg::INPUT_SCALE_RESET;
      inverse_output_scale_q16 <= fpsig_pkg::INV_OUT_SCALE_RESET;
      act_min                  <= fpsig_pkg::ACT_MIN_RESET;
      act_max                  <= fpsig_pkg::ACT_MAX_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        fpsig_pkg::REG_INPUT_SCALE:   input_scale_q16 <= cfg_data[23:0];
        fpsig_pkg::REG_INV_OUT_SCALE: inverse_output_scale_q16 <= cfg_data[30:0];
        fpsig_pkg::REG_ACT_MIN:       act_min <= signed'(cfg_data[7:0]);
        fpsig_pkg::REG_ACT_MAX:       act_max <= signed'(cfg_data[7:0]);
        default: ;
      endcase
    end
  end

  // global advance: the pipe moves unless the output holds an untaken result
  logic en;
  assign en = !result_valid || result_ready;
  assign sample_ready = en;

  // stage 1: |z| = |sample| * scale
  logic        s1_valid, s1_neg, s1_last;
  logic [31:0] s1_a;
  logic [7:0]  mag;
  assign mag = sample[7] ? (~sample + 8'd1) : sample;

  // stage 2: t = |z| / ln2, split into integer and fraction
  logic        s2_valid, s2_neg, s2_last, s2_kbig;
  logic [4:0]  s2_k;
  logic [15:0] s2_f;
  logic [48:0] t_prod;
  assign t_prod = 49'(s1_a) * 49'(fpsig_pkg::INV_LN2_Q16);

  // stage 3: f^2
  logic        s3_valid, s3_neg, s3_last, s3_kbig;
  logic [4:0]  s3_k;
  logic [15:0] s3_f, s3_f2;
  logic [31:0] ff_prod;
  assign ff_prod = s2_f * s2_f;

  // stage 4: f^3 and the first two polynomial terms
  logic        s4_valid, s4_neg, s4_last, s4_kbig;
  logic [4:0]  s4_k;
  logic [15:0] s4_f3, s4_c1, s4_c2;
  logic [31:0] f3_prod, c1_prod, c2_prod;
  assign f3_prod = s3_f2 * s3_f;
  assign c1_prod = fpsig_pkg::POLY_C1 * s3_f;
  assign c2_prod = fpsig_pkg::POLY_C2 * s3_f2;

  // stage 5: polynomial sum, limited to 0..1.0
  logic        s5_valid, s5_neg, s5_last, s5_kbig;
  logic [4:0]  s5_k;
  logic [16:0] s5_p;
  logic [31:0] c3_prod;
  logic signed [18:0] p_sum;
  assign c3_prod = fpsig_pkg::POLY_C3 * s4_f3;
  assign p_sum = signed'({2'b00, fpsig_pkg::Q16_ONE}) - signed'({3'b000, s4_c1})
               + signed'({3'b000, s4_c2}) - signed'({3'b000, c3_prod[31:16]});

  // stage 6: rounded shift by k, then divider operands
  logic        s6_valid, s6_last;
  logic [32:0] s6_num;
  logic [17:0] s6_den;
  logic [31:0] sh_sum;
  logic [31:0] sh_val;
  logic [16:0] e_val;
  always_comb begin
    sh_sum = {15'd0, s5_p} + (32'd1 << (s5_k - 5'd1));
    sh_val = sh_sum >> s5_k;
    if (s5_kbig) begin
      e_val = 17'd0;
    end else if (s5_k == 5'd0) begin
      e_val = s5_p;
    end else begin
      e_val = sh_val[16:0];
    end
  end

  // divider stages: one quotient bit per stage, MSB first
  logic [NS-1:0] dv_valid, dv_last;
  logic [17:0]   dv_rem [NS];
  logic [16:0]   dv_q   [NS];
  logic [32:0]   dv_num [NS];
  logic [17:0]   dv_den [NS];
  logic [18:0]   trial  [NS];
  logic [18:0]   diff   [NS];

  always_comb begin
    for (int j = 0; j < NS; j++) begin
      if (j == 0) begin
        trial[j] = {2'b00, s6_num[32:17], s6_num[NS-1-j]};
        diff[j]  = trial[j] - {1'b0, s6_den};
      end else begin
        trial[j] = {dv_rem[j-1], dv_num[j-1][NS-1-j]};
        diff[j]  = trial[j] - {1'b0, dv_den[j-1]};
      end
    end
  end

  // output scale multiply
  logic        m_valid, m_last;
  logic [47:0] m_prod;

  // rounding and clamp
  logic [48:0] rnd;
  logic signed [17:0] v_s;
  logic signed [17:0] v_lo;
  logic signed [7:0]  v_out;
  always_comb begin
    rnd  = {1'b0, m_prod} + 49'h0_8000_0000;
    v_s  = signed'({1'b0, rnd[48:32]});
    v_lo = (v_s < 18'(act_min)) ? 18'(act_min) : v_s;
    v_out = (v_lo > 18'(act_max)) ? act_max : v_lo[7:0];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      dv_valid <= '0;
      m_valid  <= 1'b0;
      result_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= sample_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      dv_valid <= {dv_valid[NS-2:0], s6_valid};
      m_valid  <= dv_valid[NS-1];
      result_valid <= m_valid;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (en) begin
      s1_a    <= 32'(mag) * 32'(input_scale_q16);
      s1_neg  <= sample[7] && (input_scale_q16 != 24'd0);
      s1_last <= last_in;

      s2_f    <= t_prod[31:16];
      s2_k    <= t_prod[36:32];
      s2_kbig <= (t_prod[47:32] >= fpsig_pkg::K_ZERO);
      s2_neg  <= s1_neg;
      s2_last <= s1_last;

      s3_f    <= s2_f;
      s3_f2   <= ff_prod[31:16];
      s3_k    <= s2_k;
      s3_kbig <= s2_kbig;
      s3_neg  <= s2_neg;
      s3_last <= s2_last;

      s4_f3   <= f3_prod[31:16];
      s4_c1   <= c1_prod[31:16];
      s4_c2   <= c2_prod[31:16];
      s4_k    <= s3_k;
      s4_kbig <= s3_kbig;
      s4_neg  <= s3_neg;
      s4_last <= s3_last;

      s5_p    <= p_sum[18] ? 17'd0 : p_sum[16:0];
      s5_k    <= s4_k;
      s5_kbig <= s4_kbig;
      s5_neg  <= s4_neg;
      s5_last <= s4_last;

      s6_den  <= {1'b0, fpsig_pkg::Q16_ONE} + {1'b0, e_val};
      s6_num  <= s5_neg ? {e_val, 16'd0} : {1'b1, 32'd0};
      s6_last <= s5_last;

      for (int j = 0; j < NS; j++) begin
        if (j == 0) begin
          dv_num[j]  <= s6_num;
          dv_den[j]  <= s6_den;
          dv_last[j] <= s6_last;
          dv_q[j]    <= {16'd0, !diff[j][18]} << (NS-1-j);
        end else begin
          dv_num[j]  <= dv_num[j-1];
          dv_den[j]  <= dv_den[j-1];
          dv_last[j] <= dv_last[j-1];
          dv_q[j]    <= dv_q[j-1] | ({16'd0, !diff[j][18]} << (NS-1-j));
        end
        dv_rem[j] <= diff[j][18] ? trial[j][17:0] : diff[j][17:0];
      end

      m_prod <= 48'(dv_q[NS-1]) * 48'(inverse_output_scale_q16);
      m_last <= dv_last[NS-1];

      result   <= v_out;
      last_out <= m_last;
    end
  end

  // exp result stays within 0..1.0, so the divisor stays in range
  a_den_range: assert property (@(posedge clk) disable iff (rst)
    s6_valid |-> (s6_den >= 18'd65536 && s6_den <= 18'd131072))
    else $error("divisor out of range");

  // remainder of the last divider stage is below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    dv_valid[NS-1] |-> (dv_rem[NS-1] < dv_den[NS-1]))
    else $error("divider remainder not reduced");

  // sigmoid quotient never exceeds 1.0
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    dv_valid[NS-1] |-> (dv_q[NS-1] <= 17'd65536))
    else $error("sigmoid above one");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!result_valid && !m_valid && dv_valid == '0))
    else $error("pipeline not empty after reset");

endmodule

### verif/tb_fixed_point_sigmoid_s8.sv
// Testbench for the fixed-point int8 sigmoid: directed table plus random traffic.
`timescale 1ns / 100ps

module tb_fixed_point_sigmoid_s8;

  localparam int LATENCY   = 24;
  localparam int MAX_CYCLE = 400000;
  localparam logic [7:0] REG_BAD_INDEX = 8'd9;

  logic              clk;
  logic              rst;
  logic              sample_valid;
  logic              sample_ready;
  logic signed [7:0] sample;
  logic              last_in;
  logic              result_valid;
  logic              result_ready;
  logic signed [7:0] result;
  logic              last_out;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [7:0]        cfg_index;
  logic [31:0]       cfg_data;

  typedef struct packed {
    logic signed [7:0] code;
    logic              last;
  } sig_result_t;

  // directed row: sample, last flag, optional typed expectation
  typedef struct {
    logic signed [7:0] smp;
    logic              lst;
    logic              known;
    logic signed [7:0] code;
  } stim_row_t;

  fixed_point_sigmoid_s8 DUT (.*);

  // shadow copy of the configuration registers
  logic [23:0]        in_scale;
  logic [30:0]        inv_scale_out;
  logic signed [7:0]  clamp_lo;
  logic signed [7:0]  clamp_hi;

  sig_result_t pending_results[$];
  int          error_count;
  int          cycle_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // exp(-a) in Q16 using the cubic exp2 polynomial
  function automatic longint exp_neg(longint a);
    longint t, k, f, f2, f3, p;
    if (a == 0) return 65536;
    t = (a * 94548) >>> 16;
    k = t >>> 16;
    f = t & 16'hFFFF;
    if (k >= 31) return 0;
    f2 = (f * f) >>> 16;
    f3 = (f2 * f) >>> 16;
    p = 65536 - ((45426 * f) >>> 16) + ((15743 * f2) >>> 16) - ((3638 * f3) >>> 16);
    if (p < 0) p = 0;
    if (k > 0) p = (p + (longint'(1) << (k - 1))) >>> k;
    if (p > 65536) p = 65536;
    return p;
  endfunction

  function automatic logic signed [7:0] sigmoid_code(logic signed [7:0] s);
    longint z, a, e, sig, v;
    z = longint'(s) * longint'(in_scale);
    a = (z < 0) ? -z : z;
    e = exp_neg(a);
    if (z >= 0) sig = (longint'(65536) * 65536) / (65536 + e);
    else sig = (e * 65536) / (65536 + e);
    v = (sig * longint'(inv_scale_out) + (longint'(1) << 31)) >>> 32;
    if (v < clamp_lo) v = clamp_lo;
    if (v > clamp_hi) v = clamp_hi;
    return v[7:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  // output monitor and checker
  always @(posedge clk) begin
    sig_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", result, 0);
      end else begin
        want = pending_results.pop_front();
        if (result !== want.code) report_mismatch("result", result, want.code);
        if (last_out !== want.last) report_mismatch("last_out", last_out, want.last);
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // send one sample transaction and queue its expectation; valid stays high
  // after the accept so that back-to-back transactions need no gap
  task automatic send_sample(input logic signed [7:0] s, input logic l,
                             input logic known, input logic signed [7:0] code);
    sig_result_t exp_item;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    last_in      <= l;
    exp_item.code = known ? code : sigmoid_code(s);
    exp_item.last = l;
    if (known && code !== sigmoid_code(s)) $display("note: table row %0d disagrees", s);
    pending_results.push_back(exp_item);
    do @(posedge clk); while (!sample_ready);
  endtask

  task automatic drain_pipeline();
    sample_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // register write while the pipeline is empty
  task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      fpsig_pkg::REG_INPUT_SCALE:   in_scale      = data[23:0];
      fpsig_pkg::REG_INV_OUT_SCALE: inv_scale_out = data[30:0];
      fpsig_pkg::REG_ACT_MIN:       clamp_lo      = data[7:0];
      fpsig_pkg::REG_ACT_MAX:       clamp_hi      = data[7:0];
      default: ;
    endcase
  endtask

  task automatic random_samples(input int n);
    for (int i = 0; i < n; i++) begin
      send_sample(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, 8'sd0);
    end
  endtask

  initial begin
    stim_row_t rows[$];
    int phase;
    error_count    = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    last_in      <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_scale      = fpsig_pkg::INPUT_SCALE_RESET;
    inv_scale_out = fpsig_pkg::INV_OUT_SCALE_RESET;
    clamp_lo      = fpsig_pkg::ACT_MIN_RESET;
    clamp_hi      = fpsig_pkg::ACT_MAX_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at reset settings: zero gives half scale, big values saturate
    rows.push_back('{8'sd0, 1'b1, 1'b1, 8'sd127});
    rows.push_back('{8'sd127, 1'b0, 1'b1, 8'sd127});
    rows.push_back('{-8'sd128, 1'b1, 1'b1, 8'sd0});
    rows.push_back('{8'sd1, 1'b0, 1'b0, 8'sd0});
    rows.push_back('{-8'sd1, 1'b0, 1'b0, 8'sd0});
    rows.push_back('{8'sd2, 1'b1, 1'b0, 8'sd0});
    rows.push_back('{-8'sd3, 1'b0, 1'b0, 8'sd0});
    rows.push_back('{8'sd22, 1'b0, 1'b0, 8'sd0});
    rows.push_back('{-8'sd22, 1'b1, 1'b0, 8'sd0});
    rows.push_back('{8'sd85, 1'b0, 1'b0, 8'sd0});
    foreach (rows[i]) send_sample(rows[i].smp, rows[i].lst, rows[i].known, rows[i].code);
    drain_pipeline();

    // output scale just under 1.0 in Q16, floor clamp at zero, fine slope settings
    write_reg(fpsig_pkg::REG_INV_OUT_SCALE, 32'h0000_FF00);
    write_reg(fpsig_pkg::REG_INPUT_SCALE, 32'h0000_1000);
    write_reg(fpsig_pkg::REG_ACT_MIN, 32'h0000_0000);
    for (int s = -8; s <= 8; s += 4) send_sample(8'(s), s[0], 1'b0, 8'sd0);
    drain_pipeline();
    // zero input scale, crossed clamps, ignored index, bits above widths
    write_reg(fpsig_pkg::REG_INPUT_SCALE, 32'hFF00_0000);
    write_reg(fpsig_pkg::REG_ACT_MIN, 32'h0000_0F50);
    write_reg(fpsig_pkg::REG_ACT_MAX, 32'h0000_0010);
    write_reg(REG_BAD_INDEX, 32'h1234_5678);
    send_sample(8'sd100, 1'b1, 1'b0, 8'sd0);
    send_sample(-8'sd100, 1'b0, 1'b0, 8'sd0);
    drain_pipeline();
    // maximum scales, full clamps
    write_reg(fpsig_pkg::REG_INPUT_SCALE, 32'h00FF_FFFF);
    write_reg(fpsig_pkg::REG_INV_OUT_SCALE, 32'hFFFF_FFFF);
    write_reg(fpsig_pkg::REG_ACT_MIN, 32'h0000_0080);
    write_reg(fpsig_pkg::REG_ACT_MAX, 32'h0000_007F);
    send_sample(8'sd1, 1'b0, 1'b0, 8'sd0);
    send_sample(-8'sd1, 1'b1, 1'b0, 8'sd0);
    drain_pipeline();

    // random phases, each with new registers and idling mix
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      write_reg(fpsig_pkg::REG_INPUT_SCALE,
                (phase < 2) ? $urandom : $urandom_range(262144));
      write_reg(fpsig_pkg::REG_INV_OUT_SCALE, (phase == 7) ? 32'h7FFF_FFFF :
                                   $urandom_range(33554432, 65536));
      write_reg(fpsig_pkg::REG_ACT_MIN, $urandom_range(255));
      write_reg(fpsig_pkg::REG_ACT_MAX, ($urandom_range(3) == 0) ? $urandom : 32'h7F);
      random_samples(60);
      // sender holds off until everything is out, then resumes
      sample_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      random_samples(60);
      drain_pipeline();
    end

    recv_stall_pct = 0;
    drain_pipeline();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
design/fpsig_pkg.sv
design/fixed_point_sigmoid_s8.sv
verif/tb_fixed_point_sigmoid_s8.sv
